### src/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

   localparam int SIZE_BITS_DEF = 24;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [1:0] {
      PH_SIZE = 2'd0,
      PH_DATA = 2'd1,
      PH_SKIP = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       bad_size;
      logic       finished;
      logic       body_valid;
      logic [7:0] body_byte;
   } result_type;

   // bit 4 flags a hex digit, low nibble is its value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### src/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Chunked HTTP body decoder. One received byte per transaction on req_, one
// result per byte on rsp_. One byte per clock unless rsp_ stalls; data
// path: input register, then decode into the result register. The chunk
// size counter is SIZE_BITS wide; a size with more significant digits raises
// bad_size. A restart transaction (req_tuser = 1) returns the decoder to the
// start of a new body and yields an all-zero result. After the last chunk
// or an error every byte yields an all-zero result until a restart.

module http_chunked_body_decoder #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // rx_byte
   input  wire        req_tuser,   // kind
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // body_byte
   output logic [1:0] rsp_tuser,   // [0] body_valid, [1] bad_size
   output logic       rsp_tlast    // finished
);

   hcbd_pkg::item_type   req_item;
   hcbd_pkg::item_type   cur_item;
   hcbd_pkg::result_type cur_result;
   hcbd_pkg::result_type rsp_result;
   logic                 cur_valid;
   logic                 out_ready;

   assign req_item.kind    = req_tuser;
   assign req_item.rx_byte = req_tdata;

   hcbd_in_stage u_in (
      .clock   (clock),
      .reset   (reset),
      .s_valid (req_tvalid),
      .s_ready (req_tready),
      .s_item  (req_item),
      .m_valid (cur_valid),
      .m_ready (out_ready),
      .m_item  (cur_item)
   );

   hcbd_core #(
      .SIZE_BITS (SIZE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (cur_valid && out_ready),
      .item   (cur_item),
      .result (cur_result)
   );

   hcbd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .s_valid  (cur_valid),
      .s_ready  (out_ready),
      .s_result (cur_result),
      .m_valid  (rsp_tvalid),
      .m_ready  (rsp_tready),
      .m_result (rsp_result)
   );

   assign rsp_tdata = rsp_result.body_byte;
   assign rsp_tuser = {rsp_result.bad_size, rsp_result.body_valid};
   assign rsp_tlast = rsp_result.finished;

endmodule

`default_nettype wire

### src/hcbd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_in_stage (
   input  wire                clock,
   input  wire                reset,
   input  wire                s_valid,
   output logic               s_ready,
   input  hcbd_pkg::item_type s_item,
   output logic               m_valid,
   input  wire                m_ready,
   output hcbd_pkg::item_type m_item
);

   logic               valid_ff;
   hcbd_pkg::item_type item_ff;

   assign s_ready = !valid_ff || m_ready;
   assign m_valid = valid_ff;
   assign m_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (s_ready) begin
         valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s_ready && s_valid) begin
         item_ff <= s_item;
      end
   end

endmodule

`default_nettype wire

### src/hcbd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_core #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step,
   input  hcbd_pkg::item_type   item,
   output hcbd_pkg::result_type result
);

   hcbd_pkg::phase_type  phase_ff, phase_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   logic                 digit_seen_ff, digit_seen_in;
   logic                 size_closed_ff, size_closed_in;
   logic                 trailer_left_ff, trailer_left_in;

   logic [4:0]           hex;
   logic                 blank;
   logic [SIZE_BITS-1:0] rem_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= hcbd_pkg::PH_SIZE;
         remaining_ff    <= '0;
         digit_seen_ff   <= 1'b0;
         size_closed_ff  <= 1'b0;
         trailer_left_ff <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         remaining_ff    <= remaining_in;
         digit_seen_ff   <= digit_seen_in;
         size_closed_ff  <= size_closed_in;
         trailer_left_ff <= trailer_left_in;
      end
   end

   assign hex     = hcbd_pkg::hex_decode(item.rx_byte);
   assign blank   = (item.rx_byte == hcbd_pkg::CHAR_SPACE) ||
                    (item.rx_byte == hcbd_pkg::CHAR_TAB);
   assign rem_dec = remaining_ff - {{(SIZE_BITS-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in        = phase_ff;
      remaining_in    = remaining_ff;
      digit_seen_in   = digit_seen_ff;
      size_closed_in  = size_closed_ff;
      trailer_left_in = trailer_left_ff;
      result          = '0;

      if (item.kind == hcbd_pkg::KIND_RESTART) begin
         phase_in        = hcbd_pkg::PH_SIZE;
         remaining_in    = '0;
         digit_seen_in   = 1'b0;
         size_closed_in  = 1'b0;
         trailer_left_in = 1'b0;
      end else begin
         case (phase_ff)
            hcbd_pkg::PH_SIZE: begin
               if (!size_closed_ff) begin
                  if (!digit_seen_ff && blank) begin
                     // leading blank, skipped
                  end else if (hex[4]) begin
                     // top nibble busy: one more digit would overflow
                     if (remaining_ff[SIZE_BITS-1 -: 4] != 4'd0) begin
                        result.bad_size = 1'b1;
                        phase_in        = hcbd_pkg::PH_DONE;
                     end else begin
                        remaining_in  = {remaining_ff[SIZE_BITS-5:0], hex[3:0]};
                        digit_seen_in = 1'b1;
                     end
                  end else begin
                     size_closed_in = 1'b1;
                     if (!digit_seen_ff) begin
                        result.bad_size = 1'b1;
                        phase_in        = hcbd_pkg::PH_DONE;
                     end
                  end
               end
               if (phase_in == hcbd_pkg::PH_SIZE && size_closed_in &&
                   item.rx_byte == hcbd_pkg::CHAR_LF) begin
                  digit_seen_in  = 1'b0;
                  size_closed_in = 1'b0;
                  if (remaining_ff == '0) begin
                     result.finished = 1'b1;
                     phase_in        = hcbd_pkg::PH_DONE;
                  end else begin
                     phase_in = hcbd_pkg::PH_DATA;
                  end
               end
            end
            hcbd_pkg::PH_DATA: begin
               result.body_byte  = item.rx_byte;
               result.body_valid = 1'b1;
               remaining_in      = rem_dec;
               if (rem_dec == '0) begin
                  phase_in        = hcbd_pkg::PH_SKIP;
                  trailer_left_in = 1'b1;
               end
            end
            hcbd_pkg::PH_SKIP: begin
               if (trailer_left_ff) begin
                  trailer_left_in = 1'b0;
               end else begin
                  phase_in       = hcbd_pkg::PH_SIZE;
                  remaining_in   = '0;
                  digit_seen_in  = 1'b0;
                  size_closed_in = 1'b0;
               end
            end
            default: begin
               // body ended: wait for restart
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### src/hcbd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_out_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  s_valid,
   output logic                 s_ready,
   input  hcbd_pkg::result_type s_result,
   output logic                 m_valid,
   input  wire                  m_ready,
   output hcbd_pkg::result_type m_result
);

   logic                 valid_ff;
   hcbd_pkg::result_type result_ff;

   assign s_ready  = !valid_ff || m_ready;
   assign m_valid  = valid_ff;
   assign m_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (s_ready) begin
         valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s_ready && s_valid) begin
         result_ff <= s_result;
      end
   end

endmodule

`default_nettype wire

### src/hcbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire [1:0] rsp_tuser,
   input wire       rsp_tlast
);

   // a stalled transaction holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // no result can be out the cycle after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid right after reset");

   // a data byte is never also an end or error marker
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tlast && !rsp_tuser[1])
      else $error("body byte flagged as finished or bad size");

   // non-data results carry zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("nonzero tdata without body_valid");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

### tb/chunk_decode_monitor.sv
`timescale 1ns / 1ps

// Watches both channels of the chunked body decoder, predicts one result per
// accepted byte and compares it with what comes out on rsp_.
module chunk_decode_monitor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // rx_byte
   input  logic       req_tuser,   // kind
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // body_byte
   input  logic [1:0] rsp_tuser,   // [0] body_valid, [1] bad_size
   input  logic       rsp_tlast,   // finished
   output int         failures,
   output int         pending
);
   import hcbd_pkg::*;

   localparam int SZ = SIZE_BITS_DEF;

   phase_type     phase;
   logic [SZ-1:0] chunk_count;     // size being parsed, then data bytes left
   logic          digit_seen;
   logic          size_closed;
   logic          trailer_left;

   result_type    expected_results[$];
   result_type    want;
   int            results_seen;

   initial begin
      failures = 0;
      pending = 0;
      results_seen = 0;
   end

   task automatic report_mismatch(input string what, input int exp_val, input int got_val);
      $display("ERROR result %0d: %s expected %0h, got %0h",
               results_seen, what, exp_val, got_val);
      failures++;
   endtask

   function automatic void clear_decoder();
      phase = PH_SIZE;
      chunk_count = '0;
      digit_seen = 1'b0;
      size_closed = 1'b0;
      trailer_left = 1'b0;
   endfunction

   // Advances the decoder state by one transaction and returns its result.
   function automatic result_type decode_byte(input logic kind, input logic [7:0] c);
      result_type r;
      logic       is_hex;
      logic [3:0] nib;
      logic [7:0] folded;
      r = '0;
      folded = c | 8'h20;
      is_hex = 1'b0;
      nib = 4'd0;
      if (c >= "0" && c <= "9") begin
         is_hex = 1'b1;
         nib = c[3:0];
      end else if (folded >= "a" && folded <= "f") begin
         is_hex = 1'b1;
         nib = c[3:0] + 4'd9;
      end
      if (kind == KIND_RESTART) begin
         clear_decoder();
      end else begin
         case (phase)
            PH_SIZE: begin
               if (!size_closed) begin
                  if (!digit_seen && (c == CHAR_SPACE || c == CHAR_TAB)) begin
                     // leading blank
                  end else if (is_hex) begin
                     if (chunk_count[SZ-1 -: 4] != 4'd0) begin
                        r.bad_size = 1'b1;
                        phase = PH_DONE;
                     end else begin
                        chunk_count = {chunk_count[SZ-5:0], nib};
                        digit_seen = 1'b1;
                     end
                  end else begin
                     size_closed = 1'b1;
                     if (!digit_seen) begin
                        r.bad_size = 1'b1;
                        phase = PH_DONE;
                     end
                  end
               end
               if (phase == PH_SIZE && size_closed && c == CHAR_LF) begin
                  digit_seen = 1'b0;
                  size_closed = 1'b0;
                  if (chunk_count == '0) begin
                     r.finished = 1'b1;
                     phase = PH_DONE;
                  end else begin
                     phase = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               r.body_byte = c;
               r.body_valid = 1'b1;
               chunk_count = chunk_count - 1'b1;
               if (chunk_count == '0) begin
                  phase = PH_SKIP;
                  trailer_left = 1'b1;
               end
            end
            PH_SKIP: begin
               if (trailer_left) begin
                  trailer_left = 1'b0;
               end else begin
                  clear_decoder();
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         expected_results.delete();
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(decode_byte(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transaction, body_byte", 0, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata != want.body_byte)
                  report_mismatch("body_byte", want.body_byte, rsp_tdata);
               if (rsp_tuser[0] != want.body_valid)
                  report_mismatch("body_valid", want.body_valid, rsp_tuser[0]);
               if (rsp_tuser[1] != want.bad_size)
                  report_mismatch("bad_size", want.bad_size, rsp_tuser[1]);
               if (rsp_tlast != want.finished)
                  report_mismatch("finished", want.finished, rsp_tlast);
            end
            results_seen++;
         end
         pending <= expected_results.size();
      end
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import hcbd_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int LONG_HOLD    = 60;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // rx_byte
   logic       req_tuser;    // kind
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // body_byte
   logic [1:0] rsp_tuser;    // [0] body_valid, [1] bad_size
   logic       rsp_tlast;    // finished

   int   failures;
   int   pending;
   int   bytes_sent;
   logic idle_on;
   logic start_hold;

   http_chunked_body_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   chunk_decode_monitor watch (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Receiver: random short stalls, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (start_hold) begin
            start_hold <= 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Called right after a rising edge; returns right after the edge that
   // accepted the transaction.
   task automatic send_item(input logic kind, input logic [7:0] b);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= b;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(KIND_BYTE, s[i]);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 8'h30 + nib;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
   endfunction

   task automatic send_size_line(input int unsigned size);
      int unsigned nd;
      logic [7:0]  b;
      nd = 1;
      while ((size >> (4 * nd)) != 0 && nd < 8) nd++;
      repeat ($urandom_range(0, 2))
         send_item(KIND_BYTE, $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_text("0");
      for (int i = nd - 1; i >= 0; i--) send_item(KIND_BYTE, hex_char(4'(size >> (4 * i))));
      case ($urandom_range(0, 3))
         0: send_text("\015\n");
         1: send_text("\n");
         2: begin
            // extension: arbitrary bytes up to LF
            send_text(";");
            repeat ($urandom_range(0, 4)) begin
               b = 8'($urandom);
               if (b == CHAR_LF) b = 8'h3D;
               send_item(KIND_BYTE, b);
            end
            send_text("\n");
         end
         default: begin
            send_item(KIND_BYTE, $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
            send_text("\015\n");
         end
      endcase
   endtask

   task automatic send_body();
      int unsigned size;
      send_item(KIND_RESTART, 8'($urandom));
      repeat ($urandom_range(1, 4)) begin
         size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
         send_size_line(size);
         repeat (size) send_item(KIND_BYTE, 8'($urandom));
         if ($urandom_range(0, 3) == 0) begin
            send_item(KIND_BYTE, 8'($urandom));
            send_item(KIND_BYTE, 8'($urandom));
         end else begin
            send_text("\015\n");
         end
      end
      case ($urandom_range(0, 7))
         0: begin
            repeat ($urandom_range(0, 1)) send_item(KIND_BYTE, CHAR_SPACE);
            send_text(";\015\n");
         end
         1: begin
            // too many significant digits, leading zeros in front
            repeat ($urandom_range(0, 2)) send_text("0");
            send_item(KIND_BYTE, hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(6, 7)) send_item(KIND_BYTE, hex_char(4'($urandom)));
            repeat ($urandom_range(0, 2)) send_item(KIND_BYTE, 8'($urandom));
         end
         2: begin
            // cut off in the middle of a chunk by the next restart
            send_size_line(20);
            repeat ($urandom_range(0, 3)) send_item(KIND_BYTE, 8'($urandom));
         end
         3: repeat ($urandom_range(4, 16)) send_item(KIND_BYTE, 8'($urandom));
         default: begin
            send_size_line(0);
            repeat ($urandom_range(0, 3)) send_item(KIND_BYTE, 8'($urandom));
         end
      endcase
   endtask

   initial begin
      logic hold_done;
      logic drain_done;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      req_tuser = KIND_BYTE;
      idle_on = 1'b0;
      start_hold = 1'b0;
      bytes_sent = 0;
      hold_done = 1'b0;
      drain_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      idle_on <= 1'b1;
      send_item(KIND_RESTART, 8'hA5);
      send_text(" \t3\015\n");
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'hFF);
      send_item(KIND_BYTE, 8'h80);
      send_text("\015\n");
      send_text("0x5\n");          // 'x' closes the size field, size is zero
      send_text("Z");              // body already ended
      send_item(KIND_RESTART, 8'h5A);
      send_text("\n");             // size line without digits
      send_item(KIND_RESTART, 8'h00);
      send_text("1000000");        // seventh digit overflows
      wait_drained();

      bytes_sent = 0;
      while (bytes_sent < RANDOM_ITEMS) begin
         idle_on <= (bytes_sent < RANDOM_ITEMS - 80) && ($urandom_range(0, 3) != 0);
         if (!hold_done && bytes_sent > 150) begin
            start_hold <= 1'b1;
            hold_done = 1'b1;
         end
         if (!drain_done && bytes_sent > 300) begin
            wait_drained();
            drain_done = 1'b1;
         end
         send_body();
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (4) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
src/hcbd_pkg.sv
src/hcbd_in_stage.sv
src/hcbd_core.sv
src/hcbd_out_stage.sv
src/http_chunked_body_decoder.sv
src/hcbd_checker.sv
tb/chunk_decode_monitor.sv
tb/testbench.sv
